>>> design/tpsd_pkg.sv
// Shared types and constants for the Targa pixel stream decoder.
`default_nettype none

package tpsd_pkg;

    localparam int MAX_DIMENSION_DEFAULT = 32768;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 15;
    localparam int RUN_W       = 8;
    localparam int PIXEL_W     = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 80;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam int         HDR_REPEAT_BIT = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PIXEL_FORMAT = 3'd0,
        REG_RLE_ENABLE   = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_TOP_DOWN     = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FMT_INDEX8 = 2'd0,
        FMT_RGB555 = 2'd1,
        FMT_BGR24  = 2'd2,
        FMT_BGRA32 = 2'd3
    } pix_fmt_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_REPEAT  = 2'd1,
        PH_LITERAL = 2'd2
    } phase_t;

    typedef struct packed {
        pix_fmt_t pixel_format;
        logic     rle_enable;
        logic     top_down;
    } ctrl_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [RUN_W-1:0]   run_length;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [7:0]         pixel_index;
        logic               image_done;
    } result_t;

endpackage

`default_nettype wire

>>> design/tga_pixel_stream_decoder.sv
// Top level of the Targa pixel stream decoder.
//
// Usage:
//   s_ channel: one pixel-data byte per transaction, after header and palette.
//   m_ channel: one transaction per visible pixel run with column, row, length
//     and color; tlast marks the run that completes the last row of the image.
//   cfg port: write pixel_format, rle_enable, image_width, image_height and
//     top_down by index while the stream is idle; writes are registered before they take effect.
// Timing:
//   Each byte passes an input register, then the decode logic, then a result
//   register, which drives m_tvalid. One byte is accepted every cycle unless a
//   stall holds it off (see below); header bytes, partial pixel bytes and
//   clipped pixels produce no transaction.
// Reset (aresetn low, synchronous): both stages empty, packet and row state
//   cleared, registers return to 24-bit BGR, raw mode, 1x1, bottom-up.
// Stall: while m_tready is low with a run held, the input register fills and
//   s_tready drops until the run is taken.
`default_nettype none

module tga_pixel_stream_decoder
    import tpsd_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // data_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [M_TDATA_W-1:0]   m_tdata,   // column, row, run_length, red, green,
                                                   // blue, alpha, pixel_index, zero pad
    output logic                        m_tlast    // image_done
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    ctrl_t             ctrl;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic              out_free;
    logic              advance;
    logic [BYTE_W-1:0] byte_data;
    logic              res_valid;
    result_t           res;

    tpsd_cfg_regs #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .ctrl     (ctrl),
        .width    (width),
        .height   (height)
    );

    tpsd_byte_stage u_byte_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .advance  (advance),
        .byte_data(byte_data)
    );

    tpsd_decode_core #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_decode_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .byte_data(byte_data),
        .ctrl     (ctrl),
        .width    (width),
        .height   (height),
        .res_valid(res_valid),
        .res      (res)
    );

    tpsd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_valid(res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/tpsd_cfg_regs.sv
// Configuration registers with saturated image dimensions.
`default_nettype none

module tpsd_cfg_regs
    import tpsd_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT,
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output ctrl_t                       ctrl,
    output logic      [DIM_W-1:0]       width,
    output logic      [DIM_W-1:0]       height
);

    function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W:0] v_ext;
        v_ext = {1'b0, v};
        if (v == '0) begin
            sat_dim = DIM_W'(1);
        end else if (v_ext > (CFG_DATA_W + 1)'(MAX_DIMENSION)) begin
            sat_dim = DIM_W'(MAX_DIMENSION);
        end else begin
            sat_dim = DIM_W'(v);
        end
    endfunction

    ctrl_t              ctrl_reg, ctrl_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;

    always_comb begin
        ctrl_next   = ctrl_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_PIXEL_FORMAT: ctrl_next.pixel_format = pix_fmt_t'(cfg_wdata[1:0]);
                REG_RLE_ENABLE:   ctrl_next.rle_enable = cfg_wdata[0];
                REG_IMAGE_WIDTH:  width_next = sat_dim(cfg_wdata);
                REG_IMAGE_HEIGHT: height_next = sat_dim(cfg_wdata);
                REG_TOP_DOWN:     ctrl_next.top_down = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.pixel_format <= FMT_BGR24;
            ctrl_reg.rle_enable   <= 1'b0;
            ctrl_reg.top_down     <= 1'b0;
            width_reg             <= DIM_W'(1);
            height_reg            <= DIM_W'(1);
        end else begin
            ctrl_reg   <= ctrl_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign ctrl   = ctrl_reg;
    assign width  = width_reg;
    assign height = height_reg;

endmodule

`default_nettype wire

>>> design/tpsd_byte_stage.sv
// Input register stage for incoming data bytes.
`default_nettype none

module tpsd_byte_stage
    import tpsd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                 out_free,
    output logic                      advance,
    output logic      [BYTE_W-1:0]    byte_data
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              accept;

    assign advance  = valid_reg && out_free;
    assign s_tready = !valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept) begin
            valid_next = 1'b1;
            data_next  = s_tdata[BYTE_W-1:0];
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign byte_data = data_reg;

endmodule

`default_nettype wire

>>> design/tpsd_decode_core.sv
// Packet, pixel assembly and row tracking state with run result generation.
`default_nettype none

module tpsd_decode_core
    import tpsd_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT,
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] byte_data,
    input  wire ctrl_t             ctrl,
    input  wire logic [DIM_W-1:0]  width,
    input  wire logic [DIM_W-1:0]  height,
    output logic                   res_valid,
    output result_t                res
);

    localparam int SUM_W = ((DIM_W > RUN_W) ? DIM_W : RUN_W) + 1;

    phase_t             phase_reg, phase_next;
    logic [6:0]         remain_reg, remain_next;
    logic [1:0]         byte_idx_reg, byte_idx_next;
    logic [PIXEL_W-1:0] pixel_reg, pixel_next;
    logic [DIM_W-1:0]   row_pos_reg, row_pos_next;
    logic [DIM_W-1:0]   rows_done_reg, rows_done_next;

    logic               take;
    logic               row_close;
    logic [RUN_W-1:0]   run_len;
    logic [PIXEL_W-1:0] asm_pixel;
    logic               pix_done;

    logic [SUM_W-1:0]   x_ext, n_ext, w_ext, h_ext, gap, end_pos, rd_inc;
    logic               in_row;
    logic               last_row;
    logic [RUN_W-1:0]   vis;
    logic [DIM_W-1:0]   pos_after;
    logic [DIM_W-1:0]   y_pos;
    logic [7:0]         red, green, blue, alpha, pixel_index;

    always_comb begin
        take      = 1'b0;
        row_close = 1'b0;
        run_len   = RUN_W'(1);
        if (!ctrl.rle_enable) begin
            take      = 1'b1;
            row_close = 1'b1;
        end else begin
            case (phase_reg)
                PH_REPEAT: begin
                    take      = 1'b1;
                    row_close = 1'b1;
                    run_len   = RUN_W'(remain_reg) + RUN_W'(1);
                end
                PH_LITERAL: begin
                    take      = 1'b1;
                    row_close = (remain_reg == '0);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (byte_idx_reg == '0) begin
            asm_pixel = PIXEL_W'(byte_data);
        end else begin
            asm_pixel = pixel_reg | (PIXEL_W'(byte_data) << {byte_idx_reg, 3'b000});
        end
        pix_done = take && (byte_idx_reg >= 2'(ctrl.pixel_format));
    end

    always_comb begin
        x_ext    = SUM_W'(row_pos_reg);
        n_ext    = SUM_W'(run_len);
        w_ext    = SUM_W'(width);
        h_ext    = SUM_W'(height);
        gap      = w_ext - x_ext;
        end_pos  = x_ext + n_ext;
        rd_inc   = SUM_W'(rows_done_reg) + SUM_W'(1);
        in_row   = x_ext < w_ext;
        last_row = rd_inc >= h_ext;
        vis      = (n_ext < gap) ? run_len : RUN_W'(gap);
        pos_after = (end_pos > w_ext) ? width : DIM_W'(end_pos);
        if (ctrl.top_down) begin
            y_pos = rows_done_reg;
        end else if (rows_done_reg < height) begin
            y_pos = height - DIM_W'(1) - rows_done_reg;
        end else begin
            y_pos = '0;
        end
    end

    always_comb begin
        red         = 8'd0;
        green       = 8'd0;
        blue        = 8'd0;
        alpha       = ALPHA_OPAQUE;
        pixel_index = 8'd0;
        case (ctrl.pixel_format)
            FMT_INDEX8: pixel_index = asm_pixel[7:0];
            FMT_RGB555: begin
                red   = {asm_pixel[14:10], 3'b000};
                green = {asm_pixel[9:5], 3'b000};
                blue  = {asm_pixel[4:0], 3'b000};
            end
            FMT_BGR24: begin
                blue  = asm_pixel[7:0];
                green = asm_pixel[15:8];
                red   = asm_pixel[23:16];
            end
            default: begin
                blue  = asm_pixel[7:0];
                green = asm_pixel[15:8];
                red   = asm_pixel[23:16];
                alpha = asm_pixel[31:24];
            end
        endcase
    end

    always_comb begin
        res_valid       = advance && pix_done && in_row;
        res.column      = COORD_W'(row_pos_reg);
        res.row         = COORD_W'(y_pos);
        res.run_length  = vis;
        res.red         = red;
        res.green       = green;
        res.blue        = blue;
        res.alpha       = alpha;
        res.pixel_index = pixel_index;
        res.image_done  = (n_ext >= gap) && last_row;
    end

    always_comb begin
        phase_next     = phase_reg;
        remain_next    = remain_reg;
        byte_idx_next  = byte_idx_reg;
        pixel_next     = pixel_reg;
        row_pos_next   = row_pos_reg;
        rows_done_next = rows_done_reg;
        if (advance) begin
            if (!ctrl.rle_enable) begin
                phase_next  = PH_HEADER;
                remain_next = '0;
            end else begin
                case (phase_reg)
                    PH_REPEAT: begin
                        if (pix_done) begin
                            phase_next  = PH_HEADER;
                            remain_next = '0;
                        end
                    end
                    PH_LITERAL: begin
                        if (pix_done) begin
                            if (remain_reg == '0) begin
                                phase_next = PH_HEADER;
                            end else begin
                                remain_next = remain_reg - 7'd1;
                            end
                        end
                    end
                    default: begin
                        remain_next   = byte_data[6:0];
                        phase_next    = byte_data[HDR_REPEAT_BIT] ? PH_REPEAT : PH_LITERAL;
                        byte_idx_next = '0;
                    end
                endcase
            end
            if (take) begin
                pixel_next    = asm_pixel;
                byte_idx_next = pix_done ? 2'd0 : byte_idx_reg + 2'd1;
            end
            if (pix_done) begin
                row_pos_next = pos_after;
                if (row_close && (pos_after >= width)) begin
                    row_pos_next   = '0;
                    rows_done_next = last_row ? '0 : DIM_W'(rd_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            remain_reg    <= '0;
            byte_idx_reg  <= '0;
            pixel_reg     <= '0;
            row_pos_reg   <= '0;
            rows_done_reg <= '0;
        end else begin
            phase_reg     <= phase_next;
            remain_reg    <= remain_next;
            byte_idx_reg  <= byte_idx_next;
            pixel_reg     <= pixel_next;
            row_pos_reg   <= row_pos_next;
            rows_done_reg <= rows_done_next;
        end
    end

endmodule

`default_nettype wire

>>> design/tpsd_out_stage.sv
// Result register and output stream packing.
`default_nettype none

module tpsd_out_stage
    import tpsd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 res_valid,
    input  wire result_t              res,
    output logic                      out_free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // column, row, run_length, red, green,
                                                 // blue, alpha, pixel_index, zero pad
    output logic                      m_tlast    // image_done
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (res_valid) begin
            valid_next = 1'b1;
            res_next   = res;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.pixel_index, res_reg.alpha, res_reg.blue,
                       res_reg.green, res_reg.red, res_reg.run_length,
                       res_reg.row, res_reg.column};
    assign m_tlast  = res_reg.image_done;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Testbench for the Targa pixel stream decoder: directed steps, random packet streams, then a result-side hold.
`timescale 1ns / 1ps

module testbench
    import tpsd_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          PHASE_BYTES    = 36;
    localparam int          PHASES         = 24;
    localparam logic [7:0]  RUN_COUNT_MASK = 8'h7F;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd5;

    typedef enum logic [1:0] {STEP_SETUP, STEP_PREDICTED, STEP_TYPED} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic [7:0]  data;
        result_t     run;
        pix_fmt_t    fmt;
        bit          rle;
        logic [15:0] width;
        logic [15:0] height;
        bit          top;
    } step_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    tga_pixel_stream_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // decoder state and register copies
    pix_fmt_t    fmt_q      = FMT_BGR24;
    bit          rle_q      = 1'b0;
    logic [15:0] width_q    = 16'd1;
    logic [15:0] height_q   = 16'd1;
    bit          td_q       = 1'b0;
    phase_t      phase_q    = PH_HEADER;
    int unsigned remain_q   = 0;
    int unsigned bytepos_q  = 0;
    logic [31:0] assembly_q = '0;
    int unsigned xpos_q     = 0;
    int unsigned rows_q     = 0;

    result_t pending_runs[$];
    int      mismatches     = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    logic    hold_trigger   = 1'b0;
    logic    hold_seen      = 1'b0;
    int      hold_left      = 0;
    int      quiet_cycles   = 0;
    step_t   directed_steps[$];

    function automatic int unsigned clamp_dim(input logic [15:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIMENSION_DEFAULT) return MAX_DIMENSION_DEFAULT;
        return 32'(v);
    endfunction

    function automatic void apply_setting(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [15:0] v);
        case (idx)
            REG_PIXEL_FORMAT: fmt_q = pix_fmt_t'(v[1:0]);
            REG_RLE_ENABLE:   rle_q = v[0];
            REG_IMAGE_WIDTH:  width_q = v;
            REG_IMAGE_HEIGHT: height_q = v;
            REG_TOP_DOWN:     td_q = v[0];
            default: ;
        endcase
    endfunction

    function automatic bit take_pixel_byte(input logic [7:0] b);
        int unsigned k;
        k = bytepos_q % 4;
        if (k == 0) assembly_q = {24'b0, b};
        else assembly_q |= 32'(b) << (8 * k);
        if (k >= 32'(fmt_q)) begin
            bytepos_q = 0;
            return 1'b1;
        end
        bytepos_q = k + 1;
        return 1'b0;
    endfunction

    function automatic bit emit_run(input int unsigned n, output result_t run);
        int unsigned w, h, x, vis, y;
        bit          got;
        w   = clamp_dim(width_q);
        h   = clamp_dim(height_q);
        x   = xpos_q;
        run = '0;
        got = 1'b0;
        if (x < w) begin
            vis = w - x;
            if (n < vis) vis = n;
            if (td_q) y = rows_q;
            else y = (rows_q < h) ? h - 1 - rows_q : 0;
            run.column     = 15'(x);
            run.row        = 15'(y);
            run.run_length = 8'(vis);
            run.alpha      = ALPHA_OPAQUE;
            case (fmt_q)
                FMT_INDEX8: run.pixel_index = assembly_q[7:0];
                FMT_RGB555: begin
                    run.red   = {assembly_q[14:10], 3'b000};
                    run.green = {assembly_q[9:5], 3'b000};
                    run.blue  = {assembly_q[4:0], 3'b000};
                end
                FMT_BGR24: begin
                    run.blue  = assembly_q[7:0];
                    run.green = assembly_q[15:8];
                    run.red   = assembly_q[23:16];
                end
                default: begin
                    run.blue  = assembly_q[7:0];
                    run.green = assembly_q[15:8];
                    run.red   = assembly_q[23:16];
                    run.alpha = assembly_q[31:24];
                end
            endcase
            run.image_done = (x + vis >= w) && (rows_q + 1 >= h);
            got = 1'b1;
        end
        x      = x + n;
        xpos_q = (x > w) ? w : x;
        return got;
    endfunction

    function automatic void close_row();
        int unsigned w, h;
        w = clamp_dim(width_q);
        h = clamp_dim(height_q);
        if (xpos_q >= w) begin
            xpos_q = 0;
            rows_q = (rows_q + 1 >= h) ? 0 : (rows_q + 1) & 16'hFFFF;
        end
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output result_t run);
        bit got;
        got = 1'b0;
        run = '0;
        if (!rle_q) begin
            phase_q  = PH_HEADER;
            remain_q = 0;
            if (take_pixel_byte(b)) begin
                got = emit_run(1, run);
                close_row();
            end
        end else begin
            case (phase_q)
                PH_REPEAT: if (take_pixel_byte(b)) begin
                    got      = emit_run(remain_q + 1, run);
                    phase_q  = PH_HEADER;
                    remain_q = 0;
                    close_row();
                end
                PH_LITERAL: if (take_pixel_byte(b)) begin
                    got = emit_run(1, run);
                    if (remain_q == 0) begin
                        phase_q = PH_HEADER;
                        close_row();
                    end else begin
                        remain_q--;
                    end
                end
                default: begin
                    remain_q  = 32'(b & RUN_COUNT_MASK);
                    phase_q   = b[HDR_REPEAT_BIT] ? PH_REPEAT : PH_LITERAL;
                    bytepos_q = 0;
                end
            endcase
        end
        return got;
    endfunction

    function automatic result_t unpack_run(input logic [M_TDATA_W-1:0] d, input logic last);
        result_t r;
        r.column      = d[14:0];
        r.row         = d[29:15];
        r.run_length  = d[37:30];
        r.red         = d[45:38];
        r.green       = d[53:46];
        r.blue        = d[61:54];
        r.alpha       = d[69:62];
        r.pixel_index = d[77:70];
        r.image_done  = last;
        return r;
    endfunction

    function automatic step_t setup_step(input pix_fmt_t f, input bit rle,
                                         input logic [15:0] w, input logic [15:0] h,
                                         input bit td);
        step_t s;
        s.kind   = STEP_SETUP;
        s.data   = '0;
        s.run    = '0;
        s.fmt    = f;
        s.rle    = rle;
        s.width  = w;
        s.height = h;
        s.top    = td;
        return s;
    endfunction

    function automatic step_t byte_step(input logic [7:0] b);
        step_t s;
        s      = setup_step(FMT_INDEX8, 1'b0, '0, '0, 1'b0);
        s.kind = STEP_PREDICTED;
        s.data = b;
        return s;
    endfunction

    function automatic step_t run_step(input logic [7:0] b, input int col, input int rw,
                                       input int len, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] bl,
                                       input logic [7:0] a, input logic [7:0] idx,
                                       input int done);
        step_t s;
        s                  = byte_step(b);
        s.kind             = STEP_TYPED;
        s.run.column       = 15'(col);
        s.run.row          = 15'(rw);
        s.run.run_length   = 8'(len);
        s.run.red          = r;
        s.run.green        = g;
        s.run.blue         = bl;
        s.run.alpha        = a;
        s.run.pixel_index  = idx;
        s.run.image_done   = (done != 0);
        return s;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        $display("%0t mismatch in %s: expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    // drive one byte, predict on acceptance, then idle at random
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t typed_run = '0);
        result_t run;
        bit      got;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        got = decode_byte(b, run);
        if (typed) pending_runs.push_back(typed_run);
        else if (got) pending_runs.push_back(run);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        apply_setting(idx, v);
        @(posedge aclk);
    endtask

    task automatic configure(input pix_fmt_t f, input bit rle, input logic [15:0] w,
                             input logic [15:0] h, input bit td);
        write_reg(REG_PIXEL_FORMAT, 16'(f));
        write_reg(REG_RLE_ENABLE, 16'(rle));
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_TOP_DOWN, 16'(td));
        cfg_we <= 1'b0;
    endtask

    // well-formed packets with random content, some noise, cut off at the budget
    task automatic random_phase(input int budget);
        int         sent, nbytes, i;
        logic [7:0] hdr;
        sent = 0;
        while (sent < budget) begin
            if (!rle_q || $urandom_range(9) == 0) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                hdr[HDR_REPEAT_BIT] = 1'($urandom_range(1));
                hdr[6:0] = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(7));
                send_byte(hdr);
                sent++;
                nbytes = (hdr[HDR_REPEAT_BIT] ? 1 : hdr[6:0] + 1) * (32'(fmt_q) + 1);
                for (i = 0; i < nbytes && sent < budget; i++) begin
                    send_byte(8'($urandom_range(255)));
                    sent++;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_run(m_tdata, m_tlast);
            if (pending_runs.size() == 0) begin
                $display("%0t unexpected run: %p", $time, got);
                mismatches++;
            end else begin
                want = pending_runs.pop_front();
                if (got.column !== want.column)
                    note_mismatch("column", int'(want.column), int'(got.column));
                if (got.row !== want.row)
                    note_mismatch("row", int'(want.row), int'(got.row));
                if (got.run_length !== want.run_length)
                    note_mismatch("run_length", int'(want.run_length),
                                  int'(got.run_length));
                if (got.red !== want.red)
                    note_mismatch("red", int'(want.red), int'(got.red));
                if (got.green !== want.green)
                    note_mismatch("green", int'(want.green), int'(got.green));
                if (got.blue !== want.blue)
                    note_mismatch("blue", int'(want.blue), int'(got.blue));
                if (got.alpha !== want.alpha)
                    note_mismatch("alpha", int'(want.alpha), int'(got.alpha));
                if (got.pixel_index !== want.pixel_index)
                    note_mismatch("pixel_index", int'(want.pixel_index),
                                  int'(got.pixel_index));
                if (got.image_done !== want.image_done)
                    note_mismatch("image_done", int'(want.image_done),
                                  int'(got.image_done));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int          p;
        pix_fmt_t    f;
        bit          rle, td;
        logic [15:0] w, h;

        // after reset: 24-bit BGR, raw, 1x1, bottom-up
        directed_steps.push_back(byte_step(8'h00));
        directed_steps.push_back(byte_step(8'hFF));
        directed_steps.push_back(run_step(8'h80, 0, 0, 1, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00, 1));
        // gray index, 2x2 bottom-up
        directed_steps.push_back(setup_step(FMT_INDEX8, 1'b0, 16'd2, 16'd2, 1'b0));
        directed_steps.push_back(run_step(8'hFF, 0, 1, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 0));
        directed_steps.push_back(run_step(8'h00, 1, 1, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 0));
        directed_steps.push_back(run_step(8'h7F, 0, 0, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h7F, 0));
        directed_steps.push_back(run_step(8'h80, 1, 0, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 1));
        // 5-5-5 with the unused top bit set, once with all color bits set and once with them clear
        directed_steps.push_back(setup_step(FMT_RGB555, 1'b0, 16'd1, 16'd1, 1'b1));
        directed_steps.push_back(byte_step(8'hFF));
        directed_steps.push_back(run_step(8'hFF, 0, 0, 1, 8'hF8, 8'hF8, 8'hF8, 8'hFF, 8'h00, 1));
        directed_steps.push_back(byte_step(8'h00));
        directed_steps.push_back(run_step(8'h80, 0, 0, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1));
        // repeat packets, the second one clipped to the width
        directed_steps.push_back(setup_step(FMT_BGRA32, 1'b1, 16'd4, 16'd2, 1'b1));
        directed_steps.push_back(byte_step(8'h83));
        directed_steps.push_back(byte_step(8'h11));
        directed_steps.push_back(byte_step(8'h22));
        directed_steps.push_back(byte_step(8'h33));
        directed_steps.push_back(run_step(8'h44, 0, 0, 4, 8'h33, 8'h22, 8'h11, 8'h44, 8'h00, 0));
        directed_steps.push_back(byte_step(8'hFF));
        directed_steps.push_back(byte_step(8'h01));
        directed_steps.push_back(byte_step(8'h02));
        directed_steps.push_back(byte_step(8'h03));
        directed_steps.push_back(run_step(8'h04, 0, 1, 4, 8'h03, 8'h02, 8'h01, 8'h04, 8'h00, 1));
        // literal packet of three indexes
        directed_steps.push_back(setup_step(FMT_INDEX8, 1'b1, 16'd3, 16'd1, 1'b0));
        directed_steps.push_back(byte_step(8'h02));
        directed_steps.push_back(run_step(8'h05, 0, 0, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h05, 0));
        directed_steps.push_back(run_step(8'h06, 1, 0, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h06, 0));
        directed_steps.push_back(run_step(8'h07, 2, 0, 1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h07, 1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_SETUP) begin
                wait_drained();
                configure(directed_steps[i].fmt, directed_steps[i].rle,
                          directed_steps[i].width, directed_steps[i].height,
                          directed_steps[i].top);
            end else begin
                send_byte(directed_steps[i].data, directed_steps[i].kind == STEP_TYPED,
                          directed_steps[i].run);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            f   = pix_fmt_t'(p % 4);
            rle = (p < 8) ? p[2] : 1'($urandom_range(1));
            td  = 1'($urandom_range(1));
            w   = 16'($urandom_range(1, 8));
            h   = 16'($urandom_range(1, 4));
            case (p)
                0: begin w = 16'd0;     h = 16'd0;     end
                1: begin w = 16'hFFFF;  h = 16'd32768; end
                2: begin w = 16'd32768; h = 16'hFFFF;  end
                default: ;
            endcase
            if (p == 0) write_reg(REG_UNUSED, 16'hFFFF);
            configure(f, rle, w, h, td);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            random_phase(PHASE_BYTES);
        end

        // hold the result side off while bytes keep coming
        wait_drained();
        configure(FMT_INDEX8, 1'b0, 16'd8, 16'd4, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_trigger <= ~hold_trigger;
        random_phase(40);

        wait_drained();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
